// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the frame parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked on every clock edge once reset has been released.
`define CRFP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("crfp assertion failed");
// Checked on every clock edge, reset included.
`define CRFP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("crfp assertion failed");
`else
`define CRFP_ASSERT(lbl, clk, rst, prop)
`define CRFP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/crfp_pkg.sv =====
// Package with the types and constants of the camera reply frame parser.
package crfp_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ID_W = 16;
  localparam int unsigned OUTCOME_W = 3;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // Input item kinds.
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  // Frame bytes.
  localparam logic [BYTE_W-1:0] HDR_A = 8'h55;
  localparam logic [BYTE_W-1:0] HDR_B = 8'hAA;
  localparam logic [BYTE_W-1:0] HDR_C = 8'h11;
  localparam logic [BYTE_W-1:0] HDR_SUM = 8'h10;
  localparam logic [BYTE_W-1:0] CMD_INFO = 8'h29;
  localparam logic [BYTE_W-1:0] CMD_BLOCK = 8'h2A;
  localparam logic [BYTE_W-1:0] INFO_MIN_LEN = 8'd2;
  localparam logic [BYTE_W-1:0] BLOCK_MIN_LEN = 8'd10;
  localparam logic [BYTE_W-1:0] INFO_LO_IDX = 8'd0;
  localparam logic [BYTE_W-1:0] INFO_HI_IDX = 8'd1;
  localparam logic [BYTE_W-1:0] BLOCK_LO_IDX = 8'd8;
  localparam logic [BYTE_W-1:0] BLOCK_HI_IDX = 8'd9;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_TIMEOUT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_COUNT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ID_MIN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ID_MAX = 3'd4;

  // Register reset values.
  localparam logic [15:0] RST_FRAME_TIMEOUT = 16'd25;
  localparam logic [15:0] RST_MAX_COUNT = 16'd100;
  localparam logic [7:0] RST_MAX_LENGTH = 8'd12;
  localparam logic [15:0] RST_ID_MIN = 16'd1;
  localparam logic [15:0] RST_ID_MAX = 16'd6;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_FOUND = 3'd0,
    OUT_NONE = 3'd1,
    OUT_TIMEOUT = 3'd2,
    OUT_BADSUM = 3'd3,
    OUT_TOOLONG = 3'd4,
    OUT_BADINFO = 3'd5,
    OUT_BADCOUNT = 3'd6
  } outcome_t;

  typedef enum logic [4:0] {
    ST_SYNC = 5'b00001,
    ST_LEN = 5'b00010,
    ST_CMD = 5'b00100,
    ST_BODY = 5'b01000,
    ST_CHK = 5'b10000
  } stage_t;

  // Classified item passed from the front end to the parser.
  typedef struct packed {
    op_t op;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic [15:0] frame_timeout_ticks;
    logic [15:0] max_result_count;
    logic [7:0] max_content_length;
    logic [15:0] id_min;
    logic [15:0] id_max;
  } cfg_t;

endpackage

// ===== rtl/crfp_if.sv =====
// Channel interfaces of the camera reply frame parser.
interface crfp_in_if;
  logic valid;
  logic ready;
  logic [crfp_pkg::KIND_W-1:0] kind;
  logic [crfp_pkg::BYTE_W-1:0] rx_byte;
  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface crfp_out_if;
  logic valid;
  logic ready;
  logic [crfp_pkg::ID_W-1:0] box_id;
  logic [crfp_pkg::OUTCOME_W-1:0] outcome;
  modport source (output valid, output box_id, output outcome, input ready);
  modport sink (input valid, input box_id, input outcome, output ready);
endinterface

interface crfp_cfg_if;
  logic valid;
  logic ready;
  logic [crfp_pkg::CFG_INDEX_W-1:0] index;
  logic [crfp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/crfp_front.sv =====
// Front end: accepts input beats and classifies them into parser operations.
module crfp_front (
  crfp_in_if.sink in_ch,
  input logic push_ready,
  output logic push,
  output crfp_pkg::item_t push_item
);
  import crfp_pkg::*;

  logic accept;

  assign in_ch.ready = push_ready;
  assign accept = in_ch.valid && push_ready;

  // Kind 3 carries no work and is dropped here.
  always_comb begin
    push_item.data = in_ch.rx_byte;
    push_item.op = OP_START;
    push = 1'b0;
    case (in_ch.kind)
      KIND_START: begin
        push_item.op = OP_START;
        push = accept;
      end
      KIND_BYTE: begin
        push_item.op = OP_BYTE;
        push = accept;
      end
      KIND_TICK: begin
        push_item.op = OP_TICK;
        push = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/crfp_queue.sv =====
// Short queue of classified items between the front end and the parser.
`include "assert_macros.svh"
module crfp_queue #(
  parameter int unsigned DEPTH = crfp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input logic clk,
  input logic rst,
  input logic push,
  input crfp_pkg::item_t push_item,
  output logic push_ready,
  input logic pop,
  output logic pop_valid,
  output crfp_pkg::item_t pop_item
);
  import crfp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  item_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CRFP_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))
  `CRFP_ASSERT(a_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1))
  `CRFP_ASSERT(a_pop_when_held, clk, rst, pop |-> pop_valid)

endmodule

// ===== rtl/crfp_back.sv =====
// Back end: frame parser, transaction control and the result register.
`include "assert_macros.svh"
module crfp_back (
  input logic clk,
  input logic rst,
  input crfp_pkg::cfg_t cfg,
  input logic q_valid,
  input crfp_pkg::item_t q_item,
  output logic pop,
  crfp_out_if.source out_ch
);
  import crfp_pkg::*;

  stage_t stage, stage_next;
  logic busy, busy_next;
  logic [1:0] header_matched, header_matched_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] frame_command, frame_command_next;
  logic [7:0] content_index, content_index_next;
  logic [7:0] running_sum, running_sum_next;
  logic [15:0] info_count, info_count_next;
  logic [15:0] block_id, block_id_next;
  logic expecting_info, expecting_info_next;
  logic [15:0] blocks_left, blocks_left_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;

  logic out_valid;
  logic [ID_W-1:0] out_id;
  outcome_t out_code;

  logic finish;
  logic restart;
  logic [ID_W-1:0] res_id;
  outcome_t res_code;
  logic [7:0] want;
  logic [7:0] b;
  logic [7:0] sum_add;
  logic [7:0] idx_inc;
  logic [15:0] ticks_inc;
  logic [15:0] left_dec;

  assign pop = q_valid && (!out_valid || out_ch.ready);
  assign b = q_item.data;
  assign sum_add = running_sum + b;
  assign idx_inc = content_index + 8'd1;
  assign ticks_inc = (elapsed_ticks != 16'hFFFF) ? elapsed_ticks + 16'd1 : elapsed_ticks;
  assign left_dec = blocks_left - 16'd1;

  always_comb begin
    case (header_matched)
      2'd0: want = HDR_A;
      2'd1: want = HDR_B;
      default: want = HDR_C;
    endcase
  end

  always_comb begin
    stage_next = stage;
    busy_next = busy;
    header_matched_next = header_matched;
    frame_length_next = frame_length;
    frame_command_next = frame_command;
    content_index_next = content_index;
    running_sum_next = running_sum;
    info_count_next = info_count;
    block_id_next = block_id;
    expecting_info_next = expecting_info;
    blocks_left_next = blocks_left;
    elapsed_ticks_next = elapsed_ticks;
    finish = 1'b0;
    restart = 1'b0;
    res_id = '0;
    res_code = OUT_FOUND;

    if (pop) begin
      case (q_item.op)
        OP_START: begin
          busy_next = 1'b1;
          restart = 1'b1;
          info_count_next = '0;
          block_id_next = '0;
          expecting_info_next = 1'b1;
          blocks_left_next = '0;
        end
        OP_BYTE: begin
          if (busy) begin
            case (stage)
              ST_SYNC: begin
                if (b == want && header_matched >= 2'd2) begin
                  header_matched_next = '0;
                  running_sum_next = HDR_SUM;
                  stage_next = ST_LEN;
                  if (expecting_info) begin
                    info_count_next = '0;
                  end else begin
                    block_id_next = '0;
                  end
                end else if (b == want) begin
                  header_matched_next = header_matched + 2'd1;
                end else begin
                  header_matched_next = (b == HDR_A) ? 2'd1 : 2'd0;
                end
              end
              ST_LEN: begin
                frame_length_next = b;
                running_sum_next = sum_add;
                stage_next = ST_CMD;
              end
              ST_CMD: begin
                frame_command_next = b;
                running_sum_next = sum_add;
                if (frame_length > cfg.max_content_length) begin
                  finish = 1'b1;
                  res_code = OUT_TOOLONG;
                end else begin
                  content_index_next = '0;
                  stage_next = (frame_length == '0) ? ST_CHK : ST_BODY;
                end
              end
              ST_BODY: begin
                running_sum_next = sum_add;
                if (expecting_info) begin
                  if (content_index == INFO_LO_IDX) begin
                    info_count_next = {info_count[15:8], b};
                  end else if (content_index == INFO_HI_IDX) begin
                    info_count_next = {b, info_count[7:0]};
                  end
                end else begin
                  if (content_index == BLOCK_LO_IDX) begin
                    block_id_next = {block_id[15:8], b};
                  end else if (content_index == BLOCK_HI_IDX) begin
                    block_id_next = {b, block_id[7:0]};
                  end
                end
                content_index_next = idx_inc;
                if (idx_inc >= frame_length) begin
                  stage_next = ST_CHK;
                end
              end
              ST_CHK: begin
                if (b != running_sum) begin
                  finish = 1'b1;
                  res_code = OUT_BADSUM;
                end else if (expecting_info) begin
                  if (frame_command != CMD_INFO || frame_length < INFO_MIN_LEN) begin
                    finish = 1'b1;
                    res_code = OUT_BADINFO;
                  end else if (info_count == '0 || info_count > cfg.max_result_count) begin
                    finish = 1'b1;
                    res_code = OUT_BADCOUNT;
                  end else begin
                    expecting_info_next = 1'b0;
                    blocks_left_next = info_count;
                    restart = 1'b1;
                  end
                end else if (frame_command == CMD_BLOCK && frame_length >= BLOCK_MIN_LEN &&
                             block_id >= cfg.id_min && block_id <= cfg.id_max) begin
                  finish = 1'b1;
                  res_code = OUT_FOUND;
                  res_id = block_id;
                end else begin
                  blocks_left_next = left_dec;
                  if (left_dec == '0) begin
                    finish = 1'b1;
                    res_code = OUT_NONE;
                  end else begin
                    restart = 1'b1;
                  end
                end
              end
              default: begin
                stage_next = ST_SYNC;
              end
            endcase
          end
        end
        OP_TICK: begin
          if (busy) begin
            elapsed_ticks_next = ticks_inc;
            if (ticks_inc >= cfg.frame_timeout_ticks) begin
              finish = 1'b1;
              res_code = OUT_TIMEOUT;
            end
          end
        end
        default: begin
          busy_next = busy;
        end
      endcase
    end

    if (finish) begin
      busy_next = 1'b0;
    end
    if (finish || restart) begin
      stage_next = ST_SYNC;
      header_matched_next = '0;
      frame_length_next = '0;
      frame_command_next = '0;
      content_index_next = '0;
      running_sum_next = '0;
      elapsed_ticks_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= ST_SYNC;
      busy <= 1'b0;
      header_matched <= '0;
      frame_length <= '0;
      frame_command <= '0;
      content_index <= '0;
      running_sum <= '0;
      info_count <= '0;
      block_id <= '0;
      expecting_info <= 1'b1;
      blocks_left <= '0;
      elapsed_ticks <= '0;
      out_valid <= 1'b0;
    end else begin
      stage <= stage_next;
      busy <= busy_next;
      header_matched <= header_matched_next;
      frame_length <= frame_length_next;
      frame_command <= frame_command_next;
      content_index <= content_index_next;
      running_sum <= running_sum_next;
      info_count <= info_count_next;
      block_id <= block_id_next;
      expecting_info <= expecting_info_next;
      blocks_left <= blocks_left_next;
      elapsed_ticks <= elapsed_ticks_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_id <= res_id;
      out_code <= res_code;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.box_id = out_id;
  assign out_ch.outcome = out_code;

  `CRFP_ASSERT(a_idle_parser_clear, clk, rst,
    !busy |-> (stage == ST_SYNC && elapsed_ticks == '0 && header_matched == '0))
  `CRFP_ASSERT(a_id_only_when_found, clk, rst,
    (out_valid && out_code != OUT_FOUND) |-> (out_id == '0))
  `CRFP_ASSERT(a_result_ends_transaction, clk, rst, $rose(out_valid) |-> !busy)

endmodule

// ===== rtl/camera_reply_frame_parser.sv =====
// Top level of the camera reply frame parser: front end, queue, parser and registers.
//
// A start beat opens a transaction, abandoning any transaction already running; received
// byte beats are then parsed as frames 55 AA 11 len cmd content chk, where chk is the low
// eight bits of the sum of all earlier frame bytes, and millisecond tick beats count towards
// a per-frame timeout. The first frame must be an info frame giving the result count; block
// frames follow, and the first block ID inside [id_min, id_max] ends the transaction. Each
// transaction ends with exactly one result beat carrying the block ID (zero unless found)
// and an outcome code. Bytes and ticks that arrive while no transaction runs are dropped,
// as are beats of kind 3. The block takes one input beat per clock cycle: the front end
// classifies each beat in the cycle it is accepted and writes it into a short queue, and the
// parser retires one queued item per cycle, its result going to an output register. The
// parser only stalls when that register holds a result that has not been taken, and the
// input stalls only once the queue (QUEUE_DEPTH entries) has filled up behind it. A beat
// reaches its result through a queue slot and then the output register. Configuration writes
// are always taken and should only be made while no transaction is in flight.
module camera_reply_frame_parser #(
  parameter int unsigned QUEUE_DEPTH = crfp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input logic clk,
  input logic rst,
  crfp_in_if.sink in_ch,
  crfp_out_if.source out_ch,
  crfp_cfg_if.sink cfg
);
  import crfp_pkg::*;

  // Register file. Writes to indexes beyond the list are accepted and have no effect.
  cfg_t cfg_regs;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.frame_timeout_ticks <= RST_FRAME_TIMEOUT;
      cfg_regs.max_result_count <= RST_MAX_COUNT;
      cfg_regs.max_content_length <= RST_MAX_LENGTH;
      cfg_regs.id_min <= RST_ID_MIN;
      cfg_regs.id_max <= RST_ID_MAX;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_FRAME_TIMEOUT: cfg_regs.frame_timeout_ticks <= cfg.data;
        CFG_MAX_COUNT: cfg_regs.max_result_count <= cfg.data;
        CFG_MAX_LENGTH: cfg_regs.max_content_length <= cfg.data[7:0];
        CFG_ID_MIN: cfg_regs.id_min <= cfg.data;
        CFG_ID_MAX: cfg_regs.id_max <= cfg.data;
        default: begin
          cfg_regs <= cfg_regs;
        end
      endcase
    end
  end

  // Front end to queue.
  logic push;
  logic push_ready;
  item_t push_item;

  // Queue to parser.
  logic pop;
  logic q_valid;
  item_t q_item;

  crfp_front u_front (
    .in_ch(in_ch),
    .push_ready(push_ready),
    .push(push),
    .push_item(push_item)
  );

  crfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_item(push_item),
    .push_ready(push_ready),
    .pop(pop),
    .pop_valid(q_valid),
    .pop_item(q_item)
  );

  // The parser holds all transaction state and owns the result register.
  crfp_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_regs),
    .q_valid(q_valid),
    .q_item(q_item),
    .pop(pop),
    .out_ch(out_ch)
  );

endmodule

// ===== tb/crfp_reply_checker.sv =====
// Scoreboard that follows the camera reply frame parser beat by beat and checks its result beats.
`timescale 1ns / 100ps
module crfp_reply_checker (
  input logic clk,
  input logic rst,
  crfp_in_if in_ch,
  crfp_out_if out_ch,
  crfp_cfg_if cfg,
  output int unsigned err_count,
  output int unsigned pending
);
  import crfp_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0] box_id;
    outcome_t outcome;
  } reply_t;

  // Register copies.
  logic [15:0] cfg_timeout;
  logic [15:0] cfg_max_count;
  logic [7:0] cfg_max_len;
  logic [15:0] cfg_id_min;
  logic [15:0] cfg_id_max;

  // Parser state as the block should hold it.
  logic txn_open;
  stage_t stage;
  logic [1:0] hdr_seen;
  logic [7:0] frame_len;
  logic [7:0] frame_cmd;
  logic [7:0] body_idx;
  logic [7:0] frame_sum;
  logic [15:0] count_word;
  logic [15:0] id_word;
  logic want_info;
  logic [15:0] frames_left;
  logic [15:0] tick_count;

  reply_t expected_replies[$];
  int unsigned mismatches;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("MISMATCH at %0t ns: %s", $realtime, what);
  endtask

  task automatic restart_frame();
    stage = ST_SYNC;
    hdr_seen = '0;
    frame_len = '0;
    frame_cmd = '0;
    body_idx = '0;
    frame_sum = '0;
    tick_count = '0;
  endtask

  task automatic conclude(input logic [15:0] id, input outcome_t code);
    reply_t r;
    txn_open = 1'b0;
    restart_frame();
    r.box_id = id;
    r.outcome = code;
    expected_replies.push_back(r);
  endtask

  // The checksum was right: judge the frame as a whole.
  task automatic frame_complete();
    if (want_info) begin
      if (frame_cmd != CMD_INFO || frame_len < INFO_MIN_LEN) begin
        conclude('0, OUT_BADINFO);
      end else if (count_word == 0 || count_word > cfg_max_count) begin
        conclude('0, OUT_BADCOUNT);
      end else begin
        want_info = 1'b0;
        frames_left = count_word;
        restart_frame();
      end
    end else if (frame_cmd == CMD_BLOCK && frame_len >= BLOCK_MIN_LEN &&
                 id_word >= cfg_id_min && id_word <= cfg_id_max) begin
      conclude(id_word, OUT_FOUND);
    end else begin
      frames_left = frames_left - 16'd1;
      if (frames_left == 0) conclude('0, OUT_NONE);
      else restart_frame();
    end
  endtask

  task automatic take_rx(input logic [7:0] b);
    logic [7:0] want;
    case (stage)
      ST_SYNC: begin
        want = (hdr_seen == 0) ? HDR_A : (hdr_seen == 1) ? HDR_B : HDR_C;
        if (b == want) hdr_seen = hdr_seen + 2'd1;
        else hdr_seen = (b == HDR_A) ? 2'd1 : 2'd0;
        if (hdr_seen == 2'd3) begin
          hdr_seen = '0;
          frame_sum = HDR_SUM;
          stage = ST_LEN;
          if (want_info) count_word = '0;
          else id_word = '0;
        end
      end
      ST_LEN: begin
        frame_len = b;
        frame_sum = frame_sum + b;
        stage = ST_CMD;
      end
      ST_CMD: begin
        frame_cmd = b;
        frame_sum = frame_sum + b;
        if (frame_len > cfg_max_len) begin
          conclude('0, OUT_TOOLONG);
        end else begin
          body_idx = '0;
          stage = (frame_len == 0) ? ST_CHK : ST_BODY;
        end
      end
      ST_BODY: begin
        frame_sum = frame_sum + b;
        if (want_info) begin
          if (body_idx == INFO_LO_IDX) count_word[7:0] = b;
          else if (body_idx == INFO_HI_IDX) count_word[15:8] = b;
        end else begin
          if (body_idx == BLOCK_LO_IDX) id_word[7:0] = b;
          else if (body_idx == BLOCK_HI_IDX) id_word[15:8] = b;
        end
        body_idx = body_idx + 8'd1;
        if (body_idx >= frame_len) stage = ST_CHK;
      end
      default: begin
        if (b != frame_sum) conclude('0, OUT_BADSUM);
        else frame_complete();
      end
    endcase
  endtask

  task automatic parse_beat(input logic [KIND_W-1:0] kind, input logic [7:0] b);
    if (kind == KIND_START) begin
      txn_open = 1'b1;
      restart_frame();
      count_word = '0;
      id_word = '0;
      want_info = 1'b1;
      frames_left = '0;
    end else if (txn_open) begin
      if (kind == KIND_BYTE) begin
        take_rx(b);
      end else if (kind == KIND_TICK) begin
        if (tick_count < 16'hFFFF) tick_count = tick_count + 16'd1;
        if (tick_count >= cfg_timeout) conclude('0, OUT_TIMEOUT);
      end
    end
  endtask

  always @(posedge clk) begin
    reply_t exp_r;
    if (rst) begin
      cfg_timeout = RST_FRAME_TIMEOUT;
      cfg_max_count = RST_MAX_COUNT;
      cfg_max_len = RST_MAX_LENGTH;
      cfg_id_min = RST_ID_MIN;
      cfg_id_max = RST_ID_MAX;
      txn_open = 1'b0;
      restart_frame();
      count_word = '0;
      id_word = '0;
      want_info = 1'b1;
      frames_left = '0;
      expected_replies.delete();
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (expected_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat id=%0d outcome=%0d",
                                    out_ch.box_id, out_ch.outcome));
        end else begin
          exp_r = expected_replies.pop_front();
          if (out_ch.box_id !== exp_r.box_id)
            report_mismatch($sformatf("box_id %0d, expected %0d", out_ch.box_id, exp_r.box_id));
          if (out_ch.outcome !== exp_r.outcome)
            report_mismatch($sformatf("outcome %0d, expected %0d", out_ch.outcome,
                                      exp_r.outcome));
        end
      end
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        case (cfg.index)
          CFG_FRAME_TIMEOUT: cfg_timeout = cfg.data;
          CFG_MAX_COUNT: cfg_max_count = cfg.data;
          CFG_MAX_LENGTH: cfg_max_len = cfg.data[7:0];
          CFG_ID_MIN: cfg_id_min = cfg.data;
          CFG_ID_MAX: cfg_id_max = cfg.data;
          default: ;
        endcase
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) parse_beat(in_ch.kind, in_ch.rx_byte);
    end
    pending <= expected_replies.size();
    err_count <= mismatches;
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the frame parser testbench: clock, reset, stimulus, result sink and the verdict.
`timescale 1ns / 100ps
module tb_top;
  import crfp_pkg::*;

  // Beats of kind 3 carry no meaning and must simply be dropped by the block.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic clk;
  logic rst = 1'b1;

  crfp_in_if in_ch ();
  crfp_out_if out_ch ();
  crfp_cfg_if cfg_ch ();

  int unsigned mismatch_total;
  int unsigned replies_due;

  // The stimulus keeps its own idea of the registers, purely to shape frames (lengths that
  // fit, IDs near the accepted range). Prediction lives in the checker alone.
  logic [15:0] cur_timeout;
  logic [15:0] cur_max_count;
  logic [7:0] cur_max_len;
  logic [15:0] cur_id_min;
  logic [15:0] cur_id_max;

  // Percentage chance of slipping a millisecond tick in before each received byte.
  int unsigned tick_pct;

  // Random idling on both sides is switched off for one whole phase.
  logic idle_on = 1'b1;
  // Handshake between the stimulus and the result sink for the long hold-off.
  logic hold_off_req = 1'b0;
  logic hold_off_done = 1'b0;

  camera_reply_frame_parser u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg_ch)
  );

  crfp_reply_checker u_checker (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg_ch),
    .err_count(mismatch_total),
    .pending(replies_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Safety net: a run that hangs anywhere is a failure.
  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result sink. It takes beats with random back-pressure, and once during the run it
  // refuses everything for a long, counted stretch so that the output register and the
  // internal queue fill up and the input has to stall.
  initial begin : result_sink
    int unsigned held;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_ch.ready <= 1'b0;
        for (held = 0; held < 300; held++) @(posedge clk);
        hold_off_done <= 1'b1;
      end else begin
        out_ch.ready <= !(idle_on && $urandom_range(99) < 31);
      end
    end
  end

  // Offers one beat and returns at the edge where it is accepted. Valid is left high so
  // that the next beat can follow back to back; whoever stops sending lowers it.
  task automatic put_beat(input logic [KIND_W-1:0] kind, input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (tick_pct != 0 && $urandom_range(99) < tick_pct) put_beat(KIND_TICK, 8'($urandom));
    put_beat(KIND_BYTE, b);
  endtask

  task automatic tick_burst(input int unsigned n);
    repeat (n) put_beat(KIND_TICK, 8'($urandom));
  endtask

  // Sends a whole frame: header, length, command, content and checksum. The 16-bit word
  // lands in content bytes 0 and 1 of an info frame or 8 and 9 of a block frame. A frame
  // that the block will reject as too long is cut short after the command byte, since the
  // rest would only be ignored.
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                            input logic [15:0] word, input bit info_frame, input bit bad_sum);
    logic [7:0] frame_sum;
    logic [7:0] b;
    int unsigned i;
    send_byte(HDR_A);
    send_byte(HDR_B);
    send_byte(HDR_C);
    frame_sum = HDR_SUM + len + cmd;
    send_byte(len);
    send_byte(cmd);
    if (len > cur_max_len) return;
    for (i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (info_frame && i == INFO_LO_IDX) b = word[7:0];
      if (info_frame && i == INFO_HI_IDX) b = word[15:8];
      if (!info_frame && i == BLOCK_LO_IDX) b = word[7:0];
      if (!info_frame && i == BLOCK_HI_IDX) b = word[15:8];
      frame_sum = frame_sum + b;
      send_byte(b);
    end
    if (bad_sum) frame_sum = frame_sum ^ (8'h01 << $urandom_range(7));
    send_byte(frame_sum);
  endtask

  // Writes one register. Valid stays high between the writes of a burst.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic load_config(input logic [15:0] timeout_ticks, input logic [15:0] max_count,
                             input logic [7:0] max_len, input logic [15:0] id_lo,
                             input logic [15:0] id_hi);
    write_reg(CFG_FRAME_TIMEOUT, timeout_ticks);
    write_reg(CFG_MAX_COUNT, max_count);
    write_reg(CFG_MAX_LENGTH, {8'h00, max_len});
    write_reg(CFG_ID_MIN, id_lo);
    write_reg(CFG_ID_MAX, id_hi);
    cfg_ch.valid <= 1'b0;
    cur_timeout = timeout_ticks;
    cur_max_count = max_count;
    cur_max_len = max_len;
    cur_id_min = id_lo;
    cur_id_max = id_hi;
  endtask

  // Stops sending, waits for every outstanding result and then for the last dropped beats
  // to work their way through the queue, so that the block is truly idle afterwards.
  // The first edge lets the checker's count catch up with the beat just accepted.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // A random phase may leave a transaction open. A fresh transaction with a zero-length
  // frame and a spoilt checksum always ends in a bad checksum, whatever the registers say.
  task automatic close_phase();
    tick_pct = 0;
    put_beat(KIND_START, 8'($urandom));
    send_frame(CMD_INFO, 8'd0, 16'd0, 1'b1, 1'b1);
    settle();
  endtask

  // Block IDs are mostly inside the accepted range or right on its edges.
  function automatic logic [15:0] pick_id();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50 && cur_id_min <= cur_id_max)
      return 16'($urandom_range(cur_id_max, cur_id_min));
    if (pick < 65) return cur_id_min - 16'd1;
    if (pick < 80) return cur_id_max + 16'd1;
    if (pick < 90) return pick[0] ? cur_id_min : cur_id_max;
    return 16'($urandom);
  endfunction

  // One transaction, well formed most of the time: an info frame with a plausible count,
  // then block frames until one is accepted. Now and then a frame is spoilt, the count is
  // out of range, the transaction is left open for the next start to cut in, or the ticks
  // are allowed to run out.
  task automatic random_transaction();
    logic [15:0] count;
    logic [15:0] id;
    logic [7:0] len;
    logic [7:0] cmd;
    bit bad;
    int unsigned pick;
    int unsigned hi;
    int unsigned k;
    put_beat(KIND_START, 8'($urandom));
    pick = $urandom_range(3);
    repeat (pick) send_byte(($urandom_range(99) < 30) ? HDR_A : 8'($urandom));

    pick = $urandom_range(99);
    hi = (cur_max_count < 3) ? cur_max_count : 3;
    if (pick < 80) count = 16'($urandom_range(hi, 1));
    else if (pick < 88) count = 16'd0;
    else if (pick < 95) count = cur_max_count + 16'd1;
    else count = 16'($urandom);

    cmd = ($urandom_range(99) < 92) ? CMD_INFO : 8'($urandom);
    if (cur_max_len >= INFO_MIN_LEN && $urandom_range(99) < 90) begin
      hi = (cur_max_len < 6) ? cur_max_len : 6;
      len = 8'($urandom_range(hi, INFO_MIN_LEN));
    end else begin
      len = 8'($urandom_range(cur_max_len + 1));
    end
    bad = ($urandom_range(99) < 3);
    send_frame(cmd, len, count, 1'b1, bad);
    if (bad || cmd != CMD_INFO || len < INFO_MIN_LEN || len > cur_max_len ||
        count == 0 || count > cur_max_count) return;
    if ($urandom_range(99) < 5) return;
    if (cur_timeout != 0 && cur_timeout <= 64 && $urandom_range(99) < 5) begin
      tick_burst(cur_timeout);
      return;
    end

    for (k = 0; k < count && k < 4; k++) begin
      pick = $urandom_range(99);
      cmd = (pick < 88) ? CMD_BLOCK : (pick < 94) ? CMD_INFO : 8'($urandom);
      pick = $urandom_range(99);
      if (cur_max_len >= BLOCK_MIN_LEN && pick < 85) begin
        hi = (cur_max_len < 14) ? cur_max_len : 14;
        len = 8'($urandom_range(hi, BLOCK_MIN_LEN));
      end else if (cur_max_len >= BLOCK_MIN_LEN && pick < 88) begin
        len = cur_max_len;
      end else begin
        len = 8'($urandom_range((cur_max_len < BLOCK_MIN_LEN) ? cur_max_len :
                                BLOCK_MIN_LEN - 1));
      end
      id = pick_id();
      bad = ($urandom_range(99) < 2);
      send_frame(cmd, len, id, 1'b0, bad);
      if (bad || len > cur_max_len) return;
      if (cmd == CMD_BLOCK && len >= BLOCK_MIN_LEN && id >= cur_id_min && id <= cur_id_max)
        return;
    end
  endtask

  // A phase of random transactions, with the odd burst of pure noise (any kind, any byte)
  // between them, closed off so that the registers may be rewritten afterwards.
  task automatic random_phase(input int unsigned txns);
    tick_pct = 4;
    repeat (txns) begin
      if ($urandom_range(99) < 10) begin
        repeat (8) put_beat(KIND_W'($urandom_range(3)), 8'($urandom));
      end
      random_transaction();
    end
    close_phase();
  endtask

  initial begin : stimulus
    int unsigned waited;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_START;
    in_ch.rx_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_FRAME_TIMEOUT;
    cfg_ch.data = '0;
    cur_timeout = RST_FRAME_TIMEOUT;
    cur_max_count = RST_MAX_COUNT;
    cur_max_len = RST_MAX_LENGTH;
    cur_id_min = RST_ID_MIN;
    cur_id_max = RST_ID_MAX;
    tick_pct = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed part, reset values of the registers ----
    // With no transaction running, bytes, ticks and kind 3 beats must all be dropped.
    put_beat(KIND_BYTE, HDR_A);
    put_beat(KIND_TICK, 8'hFF);
    put_beat(KIND_UNUSED, 8'h00);

    // An out-of-range ID uses up one result, then the largest accepted ID is found.
    put_beat(KIND_START, 8'h00);
    send_frame(CMD_INFO, 8'd2, 16'd2, 1'b1, 1'b0);
    send_frame(CMD_BLOCK, 8'd10, 16'd9, 1'b0, 1'b0);
    send_frame(CMD_BLOCK, 8'd12, 16'd6, 1'b0, 1'b0);

    // Stray header bytes: the sync restarts, and a 55 counts as a new first header byte.
    // The smallest accepted ID is then found.
    put_beat(KIND_START, 8'h00);
    send_byte(HDR_A);
    send_byte(8'h12);
    send_byte(HDR_A);
    send_byte(HDR_B);
    send_byte(HDR_A);
    send_frame(CMD_INFO, 8'd2, 16'd1, 1'b1, 1'b0);
    send_frame(CMD_BLOCK, 8'd10, 16'd1, 1'b0, 1'b0);

    // Non-block frames (wrong command, then too short) use up the count: none valid.
    put_beat(KIND_START, 8'h00);
    send_frame(CMD_INFO, 8'd3, 16'd2, 1'b1, 1'b0);
    send_frame(CMD_INFO, 8'd10, 16'd3, 1'b0, 1'b0);
    send_frame(CMD_BLOCK, 8'd9, 16'd3, 1'b0, 1'b0);

    // Length one above the limit.
    put_beat(KIND_START, 8'h00);
    send_frame(CMD_INFO, 8'd13, 16'd1, 1'b1, 1'b0);

    // Bad info frames: wrong command, too short, and empty.
    put_beat(KIND_START, 8'h00);
    send_frame(CMD_BLOCK, 8'd2, 16'd1, 1'b1, 1'b0);
    put_beat(KIND_START, 8'h00);
    send_frame(CMD_INFO, 8'd1, 16'd1, 1'b1, 1'b0);
    put_beat(KIND_START, 8'h00);
    send_frame(CMD_INFO, 8'd0, 16'd0, 1'b1, 1'b0);

    // Result counts of zero and one above the limit.
    put_beat(KIND_START, 8'h00);
    send_frame(CMD_INFO, 8'd2, 16'd0, 1'b1, 1'b0);
    put_beat(KIND_START, 8'h00);
    send_frame(CMD_INFO, 8'd2, 16'd101, 1'b1, 1'b0);

    // Bad checksum.
    put_beat(KIND_START, 8'h00);
    send_frame(CMD_INFO, 8'd2, 16'd1, 1'b1, 1'b1);

    // A count right at the limit is accepted; a new start then abandons the transaction,
    // and the tick count restarts both at the start and after each accepted frame.
    put_beat(KIND_START, 8'h00);
    send_frame(CMD_INFO, 8'd2, 16'd100, 1'b1, 1'b0);
    send_frame(CMD_BLOCK, 8'd10, 16'd7, 1'b0, 1'b0);
    tick_burst(20);
    put_beat(KIND_START, 8'h00);
    tick_burst(24);
    send_frame(CMD_INFO, 8'd2, 16'd1, 1'b1, 1'b0);
    tick_burst(24);
    send_frame(CMD_BLOCK, 8'd11, 16'd2, 1'b0, 1'b0);

    // Timeout in the middle of a frame, then a byte that arrives too late to matter.
    put_beat(KIND_START, 8'h00);
    tick_burst(24);
    send_byte(HDR_A);
    put_beat(KIND_TICK, 8'h00);
    put_beat(KIND_BYTE, HDR_B);
    settle();

    // ---- Long hold-off at the result side ----
    // Each short transaction below gives a result, so with the sink refusing beats the
    // output register and the queue fill up and the input must stall until it lets go.
    hold_off_req <= 1'b1;
    repeat (8) begin
      put_beat(KIND_START, 8'h00);
      send_frame(CMD_INFO, 8'd13, 16'd0, 1'b1, 1'b0);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (!hold_off_done) @(posedge clk);
    settle();

    // ---- Directed part, extreme register settings ----
    // Zero timeout ends on the first tick; with a zero length limit, any content is too
    // long and an empty info frame is a bad one.
    load_config(16'd0, 16'd1, 8'd0, 16'd100, 16'd50);
    put_beat(KIND_START, 8'h00);
    put_beat(KIND_TICK, 8'h00);
    put_beat(KIND_START, 8'h00);
    send_frame(CMD_INFO, 8'd1, 16'd1, 1'b1, 1'b0);
    put_beat(KIND_START, 8'h00);
    send_frame(CMD_INFO, 8'd0, 16'd0, 1'b1, 1'b0);
    settle();

    // Widest settings: largest count, a long block frame, and ID zero found.
    load_config(16'd1, 16'hFFFF, 8'd255, 16'd0, 16'hFFFF);
    put_beat(KIND_START, 8'h00);
    send_frame(CMD_INFO, 8'd2, 16'hFFFF, 1'b1, 1'b0);
    send_frame(CMD_BLOCK, 8'd40, 16'd0, 1'b0, 1'b0);
    put_beat(KIND_START, 8'h00);
    put_beat(KIND_TICK, 8'h00);
    settle();

    // Inverted ID range accepts nothing; a count of two is over a limit of one.
    load_config(16'hFFFF, 16'd1, 8'd10, 16'd100, 16'd50);
    put_beat(KIND_START, 8'h00);
    send_frame(CMD_INFO, 8'd2, 16'd2, 1'b1, 1'b0);
    put_beat(KIND_START, 8'h00);
    send_frame(CMD_INFO, 8'd2, 16'd1, 1'b1, 1'b0);
    send_frame(CMD_BLOCK, 8'd10, 16'd75, 1'b0, 1'b0);
    settle();

    // ---- Random phases, one register setting each ----
    load_config(16'd20, 16'd3, 8'd12, 16'd1, 16'd6);
    random_phase(2);

    // Widest settings again, and no idling on either side for the whole phase.
    idle_on <= 1'b0;
    load_config(16'hFFFF, 16'hFFFF, 8'd255, 16'd0, 16'hFFFF);
    random_phase(2);
    idle_on <= 1'b1;

    load_config(16'd12, 16'd1, 8'd10, 16'd100, 16'd50);
    random_phase(1);

    load_config(16'd30, 16'd4, 8'd0, 16'd0, 16'd0);
    random_phase(1);

    load_config(16'd40, 16'd5, 8'd16, 16'h8000, 16'h80FF);
    random_phase(1);

    // ---- Drain and verdict ----
    in_ch.valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (replies_due != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (mismatch_total == 0 && replies_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/crfp_pkg.sv
rtl/crfp_if.sv
rtl/crfp_front.sv
rtl/crfp_queue.sv
rtl/crfp_back.sv
rtl/camera_reply_frame_parser.sv
tb/crfp_reply_checker.sv
tb/tb_top.sv
